// ===== sv/ldq_pkg.sv =====
// shared types and codes for the linked deque engine
package ldq_pkg;

	localparam int WORD_W  = 32;
	localparam int KIND_W  = 4;
	localparam int POS_W   = 9;
	localparam int COUNT_W = 9;

	typedef enum logic [3:0] {
		K_PUSH_FRONT = 4'd0,
		K_PUSH_BACK  = 4'd1,
		K_POP_FRONT  = 4'd2,
		K_POP_BACK   = 4'd3,
		K_INSERT     = 4'd4,
		K_REMOVE     = 4'd5,
		K_READ_AT    = 4'd6,
		K_REVERSE    = 4'd7,
		K_CLEAR      = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] data_in;
		logic [POS_W-1:0]         position;
	} in_beat_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_data;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic [1:0]               status;
	} out_beat_t;

endpackage

// ===== sv/linked_deque_engine.sv =====
// linked deque engine: doubly linked list of words in a pooled link memory
//
// usage
//   in channel  (in_valid/in_ready, in_data): one operation per beat
//   out channel (out_valid/out_ready, out_data): exactly one result per beat
//   an operation runs in a small sequencer that reads the data and link
//   memories one access per cycle (synchronous read).
//   errors, reverse and unknown kinds go from decode straight to the result;
//   pushes and end inserts go straight to the link writes. pop, read_at,
//   remove and middle insert first walk the link memory to their entry (a
//   pop reads just its end entry), each step a read plus a wait; removing
//   an end entry then also reads the new end entry's word.
//   clear rebuilds the free chain one entry per cycle.
//   throughput: one operation at a time; the next beat is taken the cycle
//   after the previous result is loaded into the output register.
//   reset: runs the same free-chain rebuild (CAPACITY cycles) before the
//   first beat is taken; in_ready stays low meanwhile.
//   the result sits in an output register; while the receiver stalls one more
//   beat can be taken and run, then the engine holds its result until the
//   register frees, and in_ready stays low meanwhile.
//   front and back words are kept in registers, so results need no extra
//   memory reads. reverse flips a direction bit that swaps the two links.
module linked_deque_engine #(
	parameter int CAPACITY   = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ldq_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ldq_pkg::out_beat_t  out_data
);
	localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int W  = ldq_pkg::WORD_W;

	// sequencer operation codes
	localparam logic [1:0] OP_INS   = 2'd0; // insert or push, entry goes in
	localparam logic [1:0] OP_DEL   = 2'd1; // remove or pop, entry comes out
	localparam logic [1:0] OP_READ  = 2'd2; // read only
	localparam logic [1:0] OP_FIRST = 2'd3; // first entry into an empty list

	typedef enum logic [9:0] {
		S_INIT   = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_DEC    = 10'b0000000100,
		S_WALK   = 10'b0000001000,
		S_WAITW  = 10'b0000010000,
		S_LINK1  = 10'b0000100000,
		S_LINK2  = 10'b0001000000,
		S_RDNB   = 10'b0010000000,
		S_RDNBW  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;

	// memories: data, forward link, backward link (direction is physical)
	logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
	logic [IW-1:0]         nxt_mem  [CAPACITY];
	logic [IW-1:0]         prv_mem  [CAPACITY];

	logic [DATA_WIDTH-1:0] data_rd_q;
	logic [IW-1:0]         nxt_rd_q, prv_rd_q;

	// memory ports
	logic [IW-1:0]         rd_addr;
	logic                  d_we, n_we, p_we;
	logic [IW-1:0]         d_wa, n_wa, p_wa;
	logic [DATA_WIDTH-1:0] d_wd;
	logic [IW-1:0]         n_wd, p_wd;

	always_ff @(posedge clk) begin
		if (d_we) data_mem[d_wa] <= d_wd;
		if (n_we) nxt_mem[n_wa] <= n_wd;
		if (p_we) prv_mem[p_wa] <= p_wd;
		data_rd_q <= data_mem[rd_addr];
		nxt_rd_q  <= nxt_mem[rd_addr];
		prv_rd_q  <= prv_mem[rd_addr];
	end

	// control and list registers
	logic [IW-1:0]         head_q, tail_q, free_q, cur_q, sav_q, nn_q;
	logic [IW-1:0]         fnext_q; // entry after the free head
	logic [CW-1:0]         count_q;
	logic                  rev_q;
	logic [CW-1:0]         steps_q;
	logic [IW-1:0]         init_q;
	logic [3:0]            kind_q;
	logic [DATA_WIDTH-1:0] word_q, front_q, back_q;
	logic [ldq_pkg::POS_W-1:0] pos_q;
	logic [W-1:0]          res_q;
	logic [1:0]            stat_q;
	logic [1:0]            op_q;
	logic                  at_front_q;

	// logical links seen through the direction bit
	logic [IW-1:0] lnext_rd, lprev_rd, lfront, lback;
	assign lnext_rd = rev_q ? prv_rd_q : nxt_rd_q;
	assign lprev_rd = rev_q ? nxt_rd_q : prv_rd_q;
	assign lfront   = rev_q ? tail_q : head_q;
	assign lback    = rev_q ? head_q : tail_q;

	function automatic logic [W-1:0] to_word(input logic [DATA_WIDTH-1:0] d);
		logic [W+DATA_WIDTH-1:0] t;
		t = {{W{1'b0}}, d};
		return t[W-1:0];
	endfunction

	// link pair (a then b) write helper outputs
	logic          lp_en;
	logic [IW-1:0] lp_a, lp_b;
	logic          fw_en;        // free-chain write on next mem (rebuild and freed entry)
	logic [IW-1:0] fw_a, fw_d;

	always_comb begin
		n_we = 1'b0; n_wa = fw_a; n_wd = fw_d;
		p_we = 1'b0; p_wa = lp_b; p_wd = lp_a;
		if (lp_en) begin
			n_we = 1'b1; p_we = 1'b1;
			if (rev_q) begin
				p_wa = lp_a; p_wd = lp_b; n_wa = lp_b; n_wd = lp_a;
			end else begin
				n_wa = lp_a; n_wd = lp_b; p_wa = lp_b; p_wd = lp_a;
			end
		end else if (fw_en) begin
			n_we = 1'b1;
		end
	end

	logic in_fire, out_fire, out_load;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	// result moves into the output register once it is free
	assign out_load  = (state_q == S_DONE) && (!out_valid || out_fire);

	logic [CW-1:0] pos_c;
	assign pos_c = CW'(pos_q);
	logic pos_big;
	assign pos_big = (ldq_pkg::POS_W > CW) && (pos_q >> CW) != '0;

	logic [IW-1:0] init_nx;
	assign init_nx = (32'(init_q) == CAPACITY - 1) ? '0 : init_q + 1'b1;

	// combinational control
	always_comb begin
		rd_addr = cur_q;
		d_we = 1'b0; d_wa = free_q; d_wd = word_q;
		lp_en = 1'b0; lp_a = '0; lp_b = '0;
		fw_en = 1'b0; fw_a = init_q; fw_d = init_nx;
		unique case (state_q)
			S_INIT: fw_en = 1'b1;
			S_IDLE: rd_addr = free_q;
			S_DEC:  rd_addr = free_q;
			S_WALK: rd_addr = cur_q;
			S_WAITW: rd_addr = cur_q;
			S_LINK1, S_LINK2, S_RDNB, S_RDNBW, S_DONE: rd_addr = cur_q;
			default: ;
		endcase
		// writes issued in the link states are set here, in this combinational
		// block, through these signals
		if (state_q == S_LINK1) begin
			unique case (op_q)
				OP_INS: begin // insert or push: new entry nn between sav and cur
					d_we = 1'b1; d_wa = nn_q;
					lp_en = 1'b1; lp_a = sav_q; lp_b = nn_q;
				end
				OP_DEL: begin lp_en = 1'b1; lp_a = sav_q; lp_b = nn_q; end
				OP_FIRST: begin // first entry: self links
					d_we = 1'b1; d_wa = nn_q;
					lp_en = 1'b1; lp_a = nn_q; lp_b = nn_q;
				end
				default: ;
			endcase
		end
		if (state_q == S_LINK2) begin
			unique case (op_q)
				OP_INS: begin lp_en = 1'b1; lp_a = nn_q; lp_b = cur_q; end
				OP_DEL: begin fw_en = 1'b1; fw_a = cur_q; fw_d = free_q; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			init_q    <= '0;
			head_q    <= '0; tail_q <= '0; free_q <= '0;
			count_q   <= '0; rev_q <= 1'b0;
			out_valid <= 1'b0;
			op_q <= OP_INS; at_front_q <= 1'b0;
			steps_q <= '0; kind_q <= '0;
			front_q <= '0; back_q <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_fire) out_valid <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_nx;
					if (32'(init_q) == CAPACITY - 1) begin
						state_q <= S_IDLE;
						if (kind_q == ldq_pkg::K_CLEAR) state_q <= S_DONE;
					end
				end
				S_IDLE: if (in_fire) begin
					kind_q <= in_data.kind;
					word_q <= DATA_WIDTH'(in_data.data_in);
					pos_q  <= in_data.position;
					state_q <= S_DEC;
				end
				S_DEC: begin
					// nxt_rd_q holds the link after the free head now
					res_q  <= '0;
					stat_q <= ldq_pkg::ST_OK;
					state_q <= S_DONE;
					nn_q <= free_q;
					fnext_q <= nxt_rd_q;
					unique case (kind_q)
						ldq_pkg::K_PUSH_FRONT, ldq_pkg::K_PUSH_BACK: begin
							if (32'(count_q) >= CAPACITY) stat_q <= ldq_pkg::ST_FULL;
							else begin
								at_front_q <= (kind_q == ldq_pkg::K_PUSH_FRONT);
								state_q <= S_LINK1;
								if (count_q == '0) op_q <= OP_FIRST;
								else begin
									op_q <= OP_INS;
									sav_q <= lback; cur_q <= lfront;
								end
							end
						end
						ldq_pkg::K_POP_FRONT, ldq_pkg::K_POP_BACK: begin
							if (count_q == '0) stat_q <= ldq_pkg::ST_RANGE;
							else begin
								at_front_q <= (kind_q == ldq_pkg::K_POP_FRONT);
								res_q <= to_word(kind_q == ldq_pkg::K_POP_FRONT ?
								                 front_q : back_q);
								cur_q <= (kind_q == ldq_pkg::K_POP_FRONT) ? lfront : lback;
								op_q <= OP_DEL;
								// read the end entry's links before unlinking it
								state_q <= S_WALK;
								steps_q <= '0;
							end
						end
						ldq_pkg::K_INSERT: begin
							if (pos_big || pos_c > count_q) stat_q <= ldq_pkg::ST_RANGE;
							else if (32'(count_q) >= CAPACITY) stat_q <= ldq_pkg::ST_FULL;
							else if (count_q == '0) begin
								op_q <= OP_FIRST; state_q <= S_LINK1;
							end else if (pos_c == '0 || pos_c == count_q) begin
								at_front_q <= (pos_c == '0);
								op_q <= OP_INS; state_q <= S_LINK1;
								sav_q <= lback; cur_q <= lfront;
							end else begin
								op_q <= OP_INS; at_front_q <= 1'b0;
								cur_q <= lfront; steps_q <= pos_c;
								state_q <= S_WALK;
							end
						end
						ldq_pkg::K_REMOVE, ldq_pkg::K_READ_AT: begin
							if (pos_big || pos_c >= count_q) stat_q <= ldq_pkg::ST_RANGE;
							else begin
								op_q <= (kind_q == ldq_pkg::K_REMOVE) ? OP_DEL : OP_READ;
								cur_q <= lfront; steps_q <= pos_c;
								state_q <= S_WALK;
							end
						end
						ldq_pkg::K_REVERSE: begin
							rev_q <= !rev_q;
							front_q <= back_q; back_q <= front_q;
						end
						ldq_pkg::K_CLEAR: begin
							head_q <= '0; tail_q <= '0; free_q <= '0;
							count_q <= '0; rev_q <= 1'b0;
							front_q <= '0; back_q <= '0;
							init_q <= '0;
							state_q <= S_INIT;
						end
						default: ;
					endcase
				end
				S_WALK: begin
					// cur_q is being read; wait for data, then step
					state_q <= S_WAITW;
				end
				S_WAITW: begin
					if (steps_q != '0) begin
						cur_q <= lnext_rd;
						steps_q <= steps_q - 1'b1;
						state_q <= S_WALK;
					end else begin
						// cur entry contents visible
						sav_q <= lprev_rd;
						nn_q  <= lnext_rd;
						unique case (op_q)
							OP_INS: begin
								nn_q <= free_q;
								state_q <= S_LINK1;
							end
							OP_READ: begin
								res_q <= to_word(data_rd_q);
								state_q <= S_DONE;
							end
							default: begin
								res_q <= to_word(data_rd_q);
								state_q <= S_LINK1;
							end
						endcase
					end
				end
				S_LINK1: begin
					if (op_q == OP_FIRST) begin
						head_q <= nn_q; tail_q <= nn_q;
						free_q <= fnext_q;
						count_q <= CW'(1);
						front_q <= word_q; back_q <= word_q;
						state_q <= S_DONE;
					end else if (op_q == OP_INS) begin
						free_q <= fnext_q;
						count_q <= count_q + 1'b1;
						state_q <= S_LINK2;
					end else begin
						// remove: sav -> nn written now; the single entry case ends in S_LINK2
						state_q <= S_LINK2;
					end
				end
				S_LINK2: begin
					if (op_q == OP_INS) begin
						if (kind_q != ldq_pkg::K_INSERT || pos_c == '0 || pos_c == count_q - 1'b1) begin
							if (at_front_q || (kind_q == ldq_pkg::K_INSERT && pos_c == '0)) begin
								if (rev_q) tail_q <= nn_q; else head_q <= nn_q;
								front_q <= word_q;
							end else begin
								if (rev_q) head_q <= nn_q; else tail_q <= nn_q;
								back_q <= word_q;
							end
						end
						state_q <= S_DONE;
					end else begin
						free_q <= cur_q;
						count_q <= count_q - 1'b1;
						if (count_q == CW'(1)) begin
							head_q <= '0; tail_q <= '0;
							front_q <= '0; back_q <= '0;
							state_q <= S_DONE;
						end else if (cur_q == lfront) begin
							if (rev_q) tail_q <= nn_q; else head_q <= nn_q;
							cur_q <= nn_q; at_front_q <= 1'b1;
							state_q <= S_RDNB;
						end else if (cur_q == lback) begin
							if (rev_q) head_q <= sav_q; else tail_q <= sav_q;
							cur_q <= sav_q; at_front_q <= 1'b0;
							state_q <= S_RDNB;
						end else state_q <= S_DONE;
					end
				end
				S_RDNB: state_q <= S_RDNBW;
				S_RDNBW: begin
					if (at_front_q) front_q <= data_rd_q; else back_q <= data_rd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold here while the previous result is still waiting
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.result_data <= (kind_q == ldq_pkg::K_CLEAR) ? '0 : res_q;
			out_data.front_value <= (count_q == '0) ? '0 : to_word(front_q);
			out_data.back_value  <= (count_q == '0) ? '0 : to_word(back_q);
			out_data.entry_count <= ldq_pkg::COUNT_W'(count_q);
			out_data.is_empty    <= (count_q == '0);
			out_data.status      <= (kind_q == ldq_pkg::K_CLEAR) ? ldq_pkg::ST_OK : stat_q;
		end
	end

endmodule
